### rtl/parallel_move_sequencer_defines.svh
// Assertion macros shared by the parallel move sequencer checkers.
`ifndef PARALLEL_MOVE_SEQUENCER_DEFINES_SVH
`define PARALLEL_MOVE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("pms check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PMS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("pms check failed");

`endif

### rtl/pms_pkg.sv
// Shared constants for the parallel move sequencer.
package pms_pkg;

	localparam int PORT_LOC_W = 8;	// location id width on the ports
	localparam int KIND_W     = 2;	// move kind tag width

endpackage

### rtl/parallel_move_sequencer.sv
// Parallel move sequencer: orders a set of parallel moves for one-at-a-time execution.
//
// Moves are loaded one per cycle (start high while busy is low) in arrival
// order; the move with set_last high starts resolution and busy rises until
// the whole set has been emitted. Moves beyond MAX_MOVES are dropped and the
// overflow flag rides on every result of that set. Results come out one beat
// per out_strobe pulse and cannot be held off. Each beat carries the move,
// its in-cycle mark, the cycles-seen flag as of that beat and result_last on
// the final beat of the set.
// Resolution walks the stored entries through a single memory read port, one entry
// per cycle. A blocker search scans from the oldest entry, a pop follows a full scan
// of the stored entries and a fetch of the new top, and the root search walks down
// from the newest entry. No clearing pass: entries are tracked by per-entry valid
// bits that reset and the end of each set clear at once.
module parallel_move_sequencer
	import pms_pkg::*;
#(
	parameter int MAX_MOVES = 16,
	parameter int LOC_BITS  = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [PORT_LOC_W-1:0] src_loc,
	input  logic [PORT_LOC_W-1:0] dst_loc,
	input  logic [KIND_W-1:0]     move_kind,
	input  logic                  set_last,
	output logic                  busy,
	output logic                  out_strobe,
	output logic [PORT_LOC_W-1:0] out_src,
	output logic [PORT_LOC_W-1:0] out_dst,
	output logic [KIND_W-1:0]     out_kind,
	output logic                  in_cycle,
	output logic                  cycles_seen,
	output logic                  overflow,
	output logic                  result_last
);

	// Entry index width, count width (holds MAX_MOVES itself), stored location width.
	localparam int IW = (MAX_MOVES > 1) ? $clog2(MAX_MOVES) : 1;
	localparam int CW = $clog2(MAX_MOVES + 1);
	localparam int LW = (LOC_BITS < PORT_LOC_W) ? LOC_BITS : PORT_LOC_W;

	typedef struct packed {
		logic [LW-1:0]     src;
		logic [LW-1:0]     dst;
		logic [KIND_W-1:0] kind;
	} entry_t;

	// ROOT: look for the newest pending move, LOAD: fetch the top move's fields,
	// SCAN: stream the entries past the comparator looking for the oldest blocker.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROOT,
		ST_LOAD,
		ST_SCAN
	} state_t;

	state_t              state_q;

	// Move store: one write port (load), one registered read port (search).
	entry_t              mem [MAX_MOVES];
	entry_t              rd_q;

	logic [MAX_MOVES-1:0] valid_q;		// entry still pending
	logic [MAX_MOVES-1:0] mark_q;		// entry found in a cycle
	logic [CW-1:0]       count_q;		// moves stored in this set
	logic [CW-1:0]       pend_q;		// moves still pending
	logic [CW-1:0]       rptr_q;		// root search pointer, walks down
	logic                cyc_q;
	logic                ovf_q;

	// Chain stack as a shift stack, top at index 0.
	logic [IW-1:0]       stk_q [MAX_MOVES];
	logic [CW-1:0]       sp_q;

	logic [IW-1:0]       root_idx_q;
	logic [LW-1:0]       root_src_q;
	entry_t              top_q;		// fields of the move on top of the stack
	logic                load_root_q;	// the pending LOAD fetches a new root

	// Scan pipeline: address issue, then compare on the registered read data.
	logic [CW-1:0]       scan_q;
	logic                cmp_vld_s1;
	logic [IW-1:0]       cmp_idx_s1;

	// Result registers.
	logic                strobe_q;
	entry_t              res_q;
	logic                res_cyc_q;
	logic                res_seen_q;
	logic                res_ovf_q;
	logic                res_last_q;

	logic                accept;
	logic                wr_en;
	entry_t              wr_entry;
	logic [CW-1:0]       rptr_m1;
	logic [IW-1:0]       ridx;
	logic                hit;
	logic                pop;
	logic [IW-1:0]       rd_addr;

	assign accept   = start && (state_q == ST_IDLE);
	assign wr_en    = accept && (count_q < CW'(MAX_MOVES));
	assign wr_entry = '{src: src_loc[LW-1:0], dst: dst_loc[LW-1:0], kind: move_kind};

	assign rptr_m1  = rptr_q - CW'(1);
	assign ridx     = rptr_m1[IW-1:0];

	// Blocker: a pending entry whose source is the top move's destination.
	// The scan runs oldest first, so the first hit is the oldest blocker.
	assign hit = (state_q == ST_SCAN) && cmp_vld_s1 && valid_q[cmp_idx_s1] &&
	             (rd_q.src == top_q.dst);
	// Nothing blocks the top move once every stored entry has been compared.
	assign pop = (state_q == ST_SCAN) && !cmp_vld_s1 && (scan_q == count_q);

	always_comb begin
		rd_addr = scan_q[IW-1:0];
		if (state_q == ST_ROOT) begin
			rd_addr = ridx;
		end else if (pop) begin
			rd_addr = stk_q[1];		// new top after the pop
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[IW-1:0]] <= wr_entry;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			mark_q      <= '0;
			count_q     <= '0;
			pend_q      <= '0;
			rptr_q      <= '0;
			cyc_q       <= 1'b0;
			ovf_q       <= 1'b0;
			for (int i = 0; i < MAX_MOVES; i++) begin
				stk_q[i] <= '0;
			end
			sp_q        <= '0;
			root_idx_q  <= '0;
			root_src_q  <= '0;
			top_q       <= '0;
			load_root_q <= 1'b0;
			scan_q      <= '0;
			cmp_vld_s1  <= 1'b0;
			cmp_idx_s1  <= '0;
			strobe_q    <= 1'b0;
			res_q       <= '0;
			res_cyc_q   <= 1'b0;
			res_seen_q  <= 1'b0;
			res_ovf_q   <= 1'b0;
			res_last_q  <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (wr_en) begin
							valid_q[count_q[IW-1:0]] <= 1'b1;
							mark_q[count_q[IW-1:0]]  <= 1'b0;
							count_q <= count_q + CW'(1);
							pend_q  <= pend_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (set_last) begin
							rptr_q  <= wr_en ? (count_q + CW'(1)) : count_q;
							state_q <= ST_ROOT;
						end
					end
				end
				ST_ROOT: begin
					if (pend_q == '0) begin
						// set done: back to an empty store
						valid_q <= '0;
						mark_q  <= '0;
						count_q <= '0;
						cyc_q   <= 1'b0;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						rptr_q <= rptr_m1;
						if (valid_q[ridx]) begin
							valid_q[ridx] <= 1'b0;
							pend_q        <= pend_q - CW'(1);
							stk_q[0]      <= ridx;
							sp_q          <= CW'(1);
							root_idx_q    <= ridx;
							load_root_q   <= 1'b1;
							state_q       <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					top_q <= rd_q;
					if (load_root_q) begin
						root_src_q <= rd_q.src;
					end
					scan_q     <= '0;
					cmp_vld_s1 <= 1'b0;
					state_q    <= ST_SCAN;
				end
				ST_SCAN: begin
					if (hit) begin
						// blocker leaves the pending set and becomes the new top
						valid_q[cmp_idx_s1] <= 1'b0;
						pend_q <= pend_q - CW'(1);
						stk_q[0] <= cmp_idx_s1;
						for (int i = 1; i < MAX_MOVES; i++) begin
							stk_q[i] <= stk_q[i-1];
						end
						sp_q  <= sp_q + CW'(1);
						top_q <= rd_q;
						if (rd_q.dst == root_src_q) begin
							mark_q[root_idx_q] <= 1'b1;
							mark_q[cmp_idx_s1] <= 1'b1;
							cyc_q <= 1'b1;
						end
						// restart the scan for the new top
						scan_q     <= '0;
						cmp_vld_s1 <= 1'b0;
					end else if (pop) begin
						strobe_q   <= 1'b1;
						res_q      <= top_q;
						res_cyc_q  <= mark_q[stk_q[0]];
						res_seen_q <= cyc_q;
						res_ovf_q  <= ovf_q;
						res_last_q <= (sp_q == CW'(1)) && (pend_q == '0);
						for (int i = 0; i < MAX_MOVES - 1; i++) begin
							stk_q[i] <= stk_q[i+1];
						end
						sp_q <= sp_q - CW'(1);
						if (sp_q == CW'(1)) begin
							state_q <= ST_ROOT;
						end else begin
							load_root_q <= 1'b0;
							state_q     <= ST_LOAD;
						end
					end else if (scan_q < count_q) begin
						cmp_vld_s1 <= 1'b1;
						cmp_idx_s1 <= scan_q[IW-1:0];
						scan_q     <= scan_q + CW'(1);
					end else begin
						cmp_vld_s1 <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign out_strobe  = strobe_q;
	assign out_src     = PORT_LOC_W'(res_q.src);
	assign out_dst     = PORT_LOC_W'(res_q.dst);
	assign out_kind    = res_q.kind;
	assign in_cycle    = res_cyc_q;
	assign cycles_seen = res_seen_q;
	assign overflow    = res_ovf_q;
	assign result_last = res_last_q;

endmodule

### rtl/pms_checker.sv
// Port-level checks for the parallel move sequencer, bound to its top level.
`include "parallel_move_sequencer_defines.svh"

module pms_port_checker
	import pms_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic [PORT_LOC_W-1:0] src_loc,
	input logic [PORT_LOC_W-1:0] dst_loc,
	input logic [KIND_W-1:0]     move_kind,
	input logic                  set_last,
	input logic                  busy,
	input logic                  out_strobe,
	input logic [PORT_LOC_W-1:0] out_src,
	input logic [PORT_LOC_W-1:0] out_dst,
	input logic [KIND_W-1:0]     out_kind,
	input logic                  in_cycle,
	input logic                  cycles_seen,
	input logic                  overflow,
	input logic                  result_last
);

	// results only show up during resolution
	`PMS_ASSERT_IMP(a_strobe_busy, clk, arst_n, out_strobe, busy)
	// the closing beat of a set starts resolution
	`PMS_ASSERT_NXT(a_last_starts, clk, arst_n, start && !busy && set_last, busy)
	// an ordinary beat only loads
	`PMS_ASSERT_NXT(a_load_only, clk, arst_n, start && !busy && !set_last, !busy)
	// the block goes idle only right after the final result of a set
	`PMS_ASSERT_IMP(a_idle_after_last, clk, arst_n, $fell(busy), $past(out_strobe && result_last))

endmodule

bind parallel_move_sequencer pms_port_checker u_pms_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.src_loc     (src_loc),
	.dst_loc     (dst_loc),
	.move_kind   (move_kind),
	.set_last    (set_last),
	.busy        (busy),
	.out_strobe  (out_strobe),
	.out_src     (out_src),
	.out_dst     (out_dst),
	.out_kind    (out_kind),
	.in_cycle    (in_cycle),
	.cycles_seen (cycles_seen),
	.overflow    (overflow),
	.result_last (result_last)
);
